FILE: rtl/sbsc_pkg.sv
// ----------------------------------------------------------------------------
// sbsc_pkg
// shared codes, field widths and sequencer states of the sorted buffer cache
// ----------------------------------------------------------------------------
package sbsc_pkg;

	localparam int unsigned SIZE_W = 31;
	localparam int unsigned ID_W   = 16;

	// operation codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GET_SCAN,
		ST_GET_SHIFT,
		ST_PUT_BACK,
		ST_PUT_HEAD,
		ST_PUT_FWD,
		ST_PUT_PLACE
	} sbsc_state_t;

endpackage

FILE: rtl/sorted_buffer_size_cache.sv
// ----------------------------------------------------------------------------
// sorted_buffer_size_cache
// cache of free buffer handles kept in ascending size order, held in one
// synchronous memory and walked one entry per cycle by a small sequencer
// ----------------------------------------------------------------------------
// sequencing: get and put walk the stored entries one per cycle from accept to done;
//   a get or a put into a non-full cache walks at most the entry count, a put into a
//   full cache at most all CACHE_ENTRIES entries
// throughput: one transfer at a time, start is taken whenever busy is low
// reset: arst_n clears the entry count and the sequencer, memory is never read
//   before written; the receiver cannot stall, results hold for the done cycle
// ----------------------------------------------------------------------------
module sorted_buffer_size_cache
	import sbsc_pkg::*;
#(
	parameter int unsigned CACHE_ENTRIES = 8,
	parameter int unsigned HANDLE_BITS   = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              operation,
	input  logic [SIZE_W-1:0] size,
	input  logic [ID_W-1:0]   buffer_id,
	output logic              busy,
	output logic              done,
	output logic              hit,
	output logic [ID_W-1:0]   found_id,
	output logic [SIZE_W-1:0] found_size,
	output logic              must_free,
	output logic [ID_W-1:0]   freed_id
);

	// index and count widths
	localparam int unsigned IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(CACHE_ENTRIES + 1);
	localparam int unsigned HW = HANDLE_BITS;
	localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(CACHE_ENTRIES);

	// entry memory: sizes and handles, one write and one read port
	logic [SIZE_W-1:0] size_mem   [CACHE_ENTRIES];
	logic [HW-1:0]     handle_mem [CACHE_ENTRIES];
	logic [SIZE_W-1:0] rd_size_q;
	logic [HW-1:0]     rd_handle_q;

	// sequencer state
	sbsc_state_t   state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [CW-1:0] cnt_q, cnt_d;

	// latched request
	logic [SIZE_W-1:0] size_q;
	logic [HW-1:0]     id_q;

	// result registers
	logic              done_q;
	logic              hit_q;
	logic [ID_W-1:0]   found_id_q;
	logic [SIZE_W-1:0] found_size_q;
	logic              must_free_q;
	logic [ID_W-1:0]   freed_id_q;

	// memory access controls
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          wr_new;      // write the latched request, else the read data
	logic          fin;         // result is complete this cycle
	logic          ld_hit;      // get found an entry that fits
	logic          ld_reject;   // full put, offered buffer is too small
	logic          ld_evict;    // full put, smallest entry leaves
	logic          accept;
	logic [IW-1:0] last_idx;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign last_idx = IW'(cnt_q - CW'(1));

	// memory: write then registered read, never the same entry in one cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_mem[wr_addr]   <= wr_new ? size_q : rd_size_q;
			handle_mem[wr_addr] <= wr_new ? id_q : rd_handle_q;
		end
		if (rd_en) begin
			rd_size_q   <= size_mem[rd_addr];
			rd_handle_q <= handle_mem[rd_addr];
		end
	end

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		cnt_d     = cnt_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		wr_en     = 1'b0;
		wr_addr   = idx_q;
		wr_new    = 1'b0;
		fin       = 1'b0;
		ld_hit    = 1'b0;
		ld_reject = 1'b0;
		ld_evict  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (operation)
						OP_GET: begin
							if (cnt_q == '0) begin
								// empty cache: immediate miss
								fin = 1'b1;
							end else begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = ST_GET_SCAN;
							end
						end
						default: begin
							if (cnt_q == FULL_CNT) begin
								rd_en   = 1'b1;
								rd_addr = '0;
								idx_d   = '0;
								state_d = ST_PUT_HEAD;
							end else if (cnt_q == '0) begin
								idx_d   = '0;
								state_d = ST_PUT_PLACE;
							end else begin
								// walk back from the last entry
								rd_en   = 1'b1;
								rd_addr = last_idx;
								idx_d   = last_idx;
								state_d = ST_PUT_BACK;
							end
						end
					endcase
				end
			end
			ST_GET_SCAN: begin
				if (size_q <= rd_size_q) begin
					ld_hit = 1'b1;
					if (idx_q == last_idx) begin
						cnt_d   = cnt_q - CW'(1);
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + IW'(1);
						idx_d   = idx_q + IW'(1);
						state_d = ST_GET_SHIFT;
					end
				end else if (idx_q == last_idx) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IW'(1);
					idx_d   = idx_q + IW'(1);
				end
			end
			ST_GET_SHIFT: begin
				// close the gap: move entry down by one
				wr_en   = 1'b1;
				wr_addr = idx_q - IW'(1);
				if (idx_q == last_idx) begin
					cnt_d   = cnt_q - CW'(1);
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q + IW'(1);
					idx_d   = idx_q + IW'(1);
				end
			end
			ST_PUT_BACK: begin
				wr_en   = 1'b1;
				wr_addr = idx_q + IW'(1);
				if (rd_size_q < size_q) begin
					// slot found above a smaller entry
					wr_new  = 1'b1;
					cnt_d   = cnt_q + CW'(1);
					fin     = 1'b1;
					state_d = ST_IDLE;
				end else if (idx_q == '0) begin
					state_d = ST_PUT_PLACE;
				end else begin
					rd_en   = 1'b1;
					rd_addr = idx_q - IW'(1);
					idx_d   = idx_q - IW'(1);
				end
			end
			ST_PUT_HEAD: begin
				if (rd_size_q > size_q) begin
					ld_reject = 1'b1;
					fin       = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					ld_evict = 1'b1;
					if (LAST_IDX == '0) begin
						idx_d   = '0;
						state_d = ST_PUT_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = IW'(1);
						idx_d   = IW'(1);
						state_d = ST_PUT_FWD;
					end
				end
			end
			ST_PUT_FWD: begin
				// evicted head: move smaller entries down until the new one fits
				wr_en   = 1'b1;
				wr_addr = idx_q - IW'(1);
				if (rd_size_q < size_q) begin
					if (idx_q == LAST_IDX) begin
						state_d = ST_PUT_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q + IW'(1);
						idx_d   = idx_q + IW'(1);
					end
				end else begin
					wr_new  = 1'b1;
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_PUT_PLACE: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_new  = 1'b1;
				if (cnt_q != FULL_CNT) begin
					cnt_d = cnt_q + CW'(1);
				end
				fin     = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			done_q  <= fin;
		end
	end

	// request latch and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			size_q       <= size;
			id_q         <= HW'(32'(buffer_id));
			hit_q        <= 1'b0;
			found_id_q   <= '0;
			found_size_q <= '0;
			must_free_q  <= 1'b0;
			freed_id_q   <= '0;
		end
		if (ld_hit) begin
			hit_q        <= 1'b1;
			found_id_q   <= ID_W'(32'(rd_handle_q));
			found_size_q <= rd_size_q;
		end
		if (ld_reject) begin
			must_free_q <= 1'b1;
			freed_id_q  <= ID_W'(32'(id_q));
		end
		if (ld_evict) begin
			must_free_q <= 1'b1;
			freed_id_q  <= ID_W'(32'(rd_handle_q));
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign found_id   = found_id_q;
	assign found_size = found_size_q;
	assign must_free  = must_free_q;
	assign freed_id   = freed_id_q;

endmodule

FILE: tb/tb_sorted_buffer_size_cache.sv
// ----------------------------------------------------------------------------
// tb_sorted_buffer_size_cache
// self-checking bench for the sorted buffer size cache: a directed opening run
// over the empty, full, equal-size and extreme-size cases, then random fill and
// drain bursts under varying sender gaps; every transfer is predicted by a
// local model of the sorted entry list and each done strobe is checked against
// the oldest prediction
// ----------------------------------------------------------------------------
module tb_sorted_buffer_size_cache
	import sbsc_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CACHE_DEPTH = 8;
	localparam int unsigned RUN_LIMIT   = 200000;
	localparam logic [SIZE_W-1:0] SIZE_TOP = {SIZE_W{1'b1}};

	// one command waiting to go to the block, with the gap policy of its phase
	typedef struct {
		logic              operation;
		logic [SIZE_W-1:0] size;
		logic [ID_W-1:0]   buffer_id;
		bit                drain;      // hold off until every result is back
		int unsigned       gap_pct;    // chance per cycle of leaving start low
	} cache_cmd_t;

	typedef struct packed {
		logic              hit;
		logic [ID_W-1:0]   found_id;
		logic [SIZE_W-1:0] found_size;
		logic              must_free;
		logic [ID_W-1:0]   freed_id;
	} cache_reply_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              start     = 1'b0;
	logic              operation = OP_GET;
	logic [SIZE_W-1:0] size      = '0;
	logic [ID_W-1:0]   buffer_id = '0;
	logic              busy;
	logic              done;
	logic              hit;
	logic [ID_W-1:0]   found_id;
	logic [SIZE_W-1:0] found_size;
	logic              must_free;
	logic [ID_W-1:0]   freed_id;

	cache_cmd_t   pending_cmds[$];
	cache_reply_t awaited_replies[$];

	// command currently on the input ports
	cache_cmd_t head_cmd;

	// local copy of the cache contents, ascending by size
	logic [SIZE_W-1:0] held_size[CACHE_DEPTH];
	logic [ID_W-1:0]   held_id[CACHE_DEPTH];
	int unsigned       held_count = 0;

	// transfer bookkeeping: sent and back counts are owned by the driver, so the drain hold
	// never races with the monitor popping the reply queue
	int unsigned sent_count = 0;
	int unsigned back_count = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;

	sorted_buffer_size_cache #(
		.CACHE_ENTRIES(CACHE_DEPTH),
		.HANDLE_BITS  (ID_W)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.size      (size),
		.buffer_id (buffer_id),
		.busy      (busy),
		.done      (done),
		.hit       (hit),
		.found_id  (found_id),
		.found_size(found_size),
		.must_free (must_free),
		.freed_id  (freed_id)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// cache model
	// ------------------------------------------------------------------------

	// close the gap left by a taken entry
	function automatic void drop_entry(int unsigned pos);
		for (int unsigned k = pos; k + 1 < held_count; k++) begin
			held_size[k] = held_size[k + 1];
			held_id[k]   = held_id[k + 1];
		end
		held_count--;
	endfunction

	// walk down from the tail; a new entry lands in front of equal sizes
	function automatic void place_entry(logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id);
		int unsigned pos;
		pos = held_count;
		while (pos > 0 && !(held_size[pos - 1] < sz)) begin
			held_size[pos] = held_size[pos - 1];
			held_id[pos]   = held_id[pos - 1];
			pos--;
		end
		held_size[pos] = sz;
		held_id[pos]   = id;
		held_count++;
	endfunction

	function automatic cache_reply_t cache_lookup_or_store(cache_cmd_t c);
		cache_reply_t r;
		bit           found;
		int unsigned  pos;
		r     = '0;
		found = 1'b0;
		pos   = 0;
		if (c.operation == OP_GET) begin
			// first entry that fits is the smallest one that fits
			for (int unsigned k = 0; k < held_count; k++) begin
				if (!found && c.size <= held_size[k]) begin
					found = 1'b1;
					pos   = k;
				end
			end
			if (found) begin
				r.hit        = 1'b1;
				r.found_id   = held_id[pos];
				r.found_size = held_size[pos];
				drop_entry(pos);
			end
		end else if (held_count < CACHE_DEPTH) begin
			place_entry(c.size, c.buffer_id);
		end else if (held_size[0] > c.size) begin
			// full and everything cached beats the offer: hand the offer back
			r.must_free = 1'b1;
			r.freed_id  = c.buffer_id;
		end else begin
			// full: evict the smallest, then store the offer
			r.must_free = 1'b1;
			r.freed_id  = held_id[0];
			drop_entry(0);
			place_entry(c.size, c.buffer_id);
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// driver: start is held until the transfer happens, idling only between
	// transfers; a command lands at the edge where start is high and busy low
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : drive_cmds
		cache_cmd_t  head;
		bit          go;
		bit          holding;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (done)
				back_count++;
			holding = start;
			if (start && !busy) begin
				awaited_replies.push_back(cache_lookup_or_store(head_cmd));
				sent_count++;
				holding = 1'b0;
			end
			if (!holding) begin
				go = 1'b0;
				if (pending_cmds.size() != 0) begin
					head = pending_cmds[0];
					if (head.drain && sent_count != back_count)
						go = 1'b0;
					else
						go = ($urandom_range(99) >= head.gap_pct);
				end
				if (go) begin
					head_cmd = pending_cmds.pop_front();
					operation <= head_cmd.operation;
					size      <= head_cmd.size;
					buffer_id <= head_cmd.buffer_id;
					start     <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: one reply per done strobe, compared with the oldest prediction
	// ------------------------------------------------------------------------
	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : watch_replies
		cache_reply_t want;
		if (arst_n && done) begin
			if (awaited_replies.size() == 0) begin
				$error("done strobe with no transfer outstanding");
				fail_count++;
			end else begin
				want = awaited_replies.pop_front();
				report_field("hit",        32'(want.hit),        32'(hit));
				report_field("found_id",   32'(want.found_id),   32'(found_id));
				report_field("found_size", 32'(want.found_size), 32'(found_size));
				report_field("must_free",  32'(want.must_free),  32'(must_free));
				report_field("freed_id",   32'(want.freed_id),   32'(freed_id));
			end
		end
	end

	// hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	task automatic queue_cmd(logic op, logic [SIZE_W-1:0] sz, logic [ID_W-1:0] id,
			bit drain, int unsigned gap_pct);
		cache_cmd_t c;
		c.operation = op;
		c.size      = sz;
		c.buffer_id = id;
		c.drain     = drain;
		c.gap_pct   = gap_pct;
		pending_cmds.push_back(c);
	endtask

	// sizes bunch up so gets hit, equal sizes recur and extremes show up
	function automatic logic [SIZE_W-1:0] pick_size(ref logic [SIZE_W-1:0] recent[$]);
		int unsigned roll;
		logic [31:0] raw;
		roll = $urandom_range(99);
		raw  = $urandom();
		if (roll < 40)
			return SIZE_W'($urandom_range(0, 31) * 32);
		else if (roll < 65)
			return raw[SIZE_W-1:0];
		else if (roll < 75)
			case ($urandom_range(3))
				0: return '0;
				1: return SIZE_W'(1);
				2: return SIZE_TOP - SIZE_W'(1);
				default: return SIZE_TOP;
			endcase
		else if (roll < 90 && recent.size() != 0)
			return recent[$urandom_range(recent.size() - 1)];
		else
			return SIZE_W'($urandom_range(0, 4096));
	endfunction

	initial begin : run_test
		logic [SIZE_W-1:0] recent[$];
		logic [SIZE_W-1:0] sz;
		logic              op;
		int unsigned       put_pct;
		int unsigned       gap_pct;

		// misses on an empty cache, smallest and largest request
		queue_cmd(OP_GET, '0,       16'h0000, 1'b0, 0);
		queue_cmd(OP_GET, SIZE_TOP, 16'hffff, 1'b0, 0);
		// fill to capacity: extreme sizes and handles, a pair of equal sizes
		queue_cmd(OP_PUT, '0,       16'h0000, 1'b0, 0);
		queue_cmd(OP_PUT, SIZE_TOP, 16'hffff, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd100,  16'h0001, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd100,  16'h0002, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd50,   16'h0003, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd200,  16'h0004, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd300,  16'h0005, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd400,  16'h0006, 1'b0, 0);
		// full, offer equals the smallest: smallest is evicted
		queue_cmd(OP_PUT, '0,       16'h0007, 1'b0, 0);
		queue_cmd(OP_GET, '0,       16'h1234, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd60,   16'h0008, 1'b0, 0);
		// full, offer below everything cached: offer is rejected
		queue_cmd(OP_PUT, 31'd10,   16'h0009, 1'b0, 0);
		queue_cmd(OP_PUT, 31'd50,   16'h000a, 1'b0, 0);
		queue_cmd(OP_GET, 31'd150,  16'h0000, 1'b0, 0);
		queue_cmd(OP_GET, SIZE_TOP, 16'h0000, 1'b0, 0);
		// nothing left that large: miss
		queue_cmd(OP_GET, SIZE_TOP, 16'h0000, 1'b0, 0);
		// equal sizes: the later insert comes out first
		queue_cmd(OP_GET, 31'd100,  16'h0000, 1'b0, 0);
		queue_cmd(OP_GET, 31'd1,    16'h0000, 1'b0, 0);
		queue_cmd(OP_GET, 31'd100,  16'h0000, 1'b0, 0);

		// random part in fill-heavy and drain-heavy bursts of 40 transfers,
		// sender gap rate switching every 200
		for (int unsigned n = 0; n < 800; n++) begin
			put_pct = ((n / 40) % 2 == 0) ? 75 : 25;
			case ((n / 200) % 4)
				0: gap_pct = 0;
				1: gap_pct = 49;
				2: gap_pct = 12;
				default: gap_pct = 49;
			endcase
			op = ($urandom_range(99) < put_pct) ? OP_PUT : OP_GET;
			sz = pick_size(recent);
			if (op == OP_PUT) begin
				recent.push_back(sz);
				if (recent.size() > 8)
					void'(recent.pop_front());
			end
			queue_cmd(op, sz, ID_W'($urandom_range(0, 65535)),
				(n % 200 == 0) || ($urandom_range(99) < 2), gap_pct);
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for the last transfer and its reply, then idle before the verdict
		do
			@(posedge clk);
		while (pending_cmds.size() != 0 || start || sent_count != back_count ||
			awaited_replies.size() != 0);
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
rtl/sbsc_pkg.sv
rtl/sorted_buffer_size_cache.sv
tb/tb_sorted_buffer_size_cache.sv
